/* src/brwm_pkg.sv */
`timescale 1ns / 1ps

package brwm_pkg;

   // Buffer geometry.
   localparam int BUF_BYTES     = 4096;
   localparam int ADDR_W        = $clog2(BUF_BYTES);
   localparam int PTR_W         = $clog2(BUF_BYTES + 1);
   localparam int BITS_PER_BYTE = 8;

   // Field widths of the request and response channels.
   localparam int MODE_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int SBITS_W   = 6;
   localparam int RATE_W    = 19;
   localparam int CHANS_W   = 4;
   localparam int FRAMES_W  = 13;
   localparam int AMOUNT_W  = 13;
   localparam int OFFSET_W  = 12;
   localparam int AVAIL_W   = 13;
   localparam int DROP_W    = 32;

   // Block length arithmetic: frames * channels, then times bytes per sample.
   localparam int BPS_W  = SBITS_W - $clog2(BITS_PER_BYTE);
   localparam int PROD_W = FRAMES_W + CHANS_W;
   localparam int LEN_W  = PROD_W + BPS_W;

   // Command queue between the front end and the execution unit.
   localparam int QDEPTH = 4;
   localparam int QIDX_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_OPEN    = 2'd0,
      MODE_DATA    = 2'd1,
      MODE_ADVANCE = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef enum logic {
      BK_RUN = 1'b0,
      BK_ADV = 1'b1
   } back_state_type;

   // One classified command as it travels through the queue.
   typedef struct packed {
      mode_type             mode;
      logic [BYTE_W-1:0]    data_byte;
      logic [SBITS_W-1:0]   sample_bits;
      logic [RATE_W-1:0]    rate_hz;
      logic [CHANS_W-1:0]   channel_count;
      logic [LEN_W-1:0]     block_len;
      logic [AMOUNT_W-1:0]  advance_amount;
      logic [OFFSET_W-1:0]  read_offset;
   } cmd_type;

endpackage

/* src/brwm_front.sv */
`timescale 1ns / 1ps

module brwm_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [brwm_pkg::MODE_W-1:0]      req_mode,
   input  logic [brwm_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic [brwm_pkg::SBITS_W-1:0]     req_sample_bits,
   input  logic [brwm_pkg::RATE_W-1:0]      req_rate_hz,
   input  logic [brwm_pkg::CHANS_W-1:0]     req_channel_count,
   input  logic [brwm_pkg::FRAMES_W-1:0]    req_frame_count,
   input  logic [brwm_pkg::AMOUNT_W-1:0]    req_advance_amount,
   input  logic [brwm_pkg::OFFSET_W-1:0]    req_read_offset,
   input  logic [brwm_pkg::QCNT_W-1:0]      q_count,
   output logic                             q_push,
   output brwm_pkg::cmd_type                q_push_cmd
);

   logic                             s1_valid_ff;
   logic                             s1_valid_in;
   brwm_pkg::cmd_type                s1_cmd_ff;
   logic [brwm_pkg::PROD_W-1:0]      s1_prod_ff;
   logic [brwm_pkg::BPS_W-1:0]       s1_bps;
   logic                             accept;

   // Hold off a new transfer unless the queue has room for it and for the
   // command already in the length stage.
   assign busy   = (({1'b0, q_count}) + (brwm_pkg::QCNT_W + 1)'(s1_valid_ff))
                   >= (brwm_pkg::QCNT_W + 1)'(brwm_pkg::QDEPTH);
   assign accept = start && !busy;

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // First stage: capture the transfer and form frames times channels.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff.mode           <= brwm_pkg::mode_type'(req_mode);
         s1_cmd_ff.data_byte      <= req_data_byte;
         s1_cmd_ff.sample_bits    <= req_sample_bits;
         s1_cmd_ff.rate_hz        <= req_rate_hz;
         s1_cmd_ff.channel_count  <= req_channel_count;
         s1_cmd_ff.block_len      <= '0;
         s1_cmd_ff.advance_amount <= req_advance_amount;
         s1_cmd_ff.read_offset    <= req_read_offset;
         s1_prod_ff <= brwm_pkg::PROD_W'(req_frame_count) *
                       brwm_pkg::PROD_W'(req_channel_count);
      end
   end

   // Second stage: scale by whole bytes per sample and hand to the queue.
   assign s1_bps = brwm_pkg::BPS_W'(s1_cmd_ff.sample_bits / brwm_pkg::BITS_PER_BYTE);

   always_comb begin
      q_push_cmd           = s1_cmd_ff;
      q_push_cmd.block_len = brwm_pkg::LEN_W'(s1_prod_ff) * brwm_pkg::LEN_W'(s1_bps);
   end

   assign q_push = s1_valid_ff;

endmodule

/* src/brwm_queue.sv */
`timescale 1ns / 1ps

module brwm_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  brwm_pkg::cmd_type            push_cmd,
   input  logic                         pop,
   output logic                         head_valid,
   output brwm_pkg::cmd_type            head_cmd,
   output logic [brwm_pkg::QCNT_W-1:0]  count
);

   brwm_pkg::cmd_type                 entry_ff [brwm_pkg::QDEPTH];
   logic [brwm_pkg::QIDX_W-1:0]       wr_idx_ff;
   logic [brwm_pkg::QIDX_W-1:0]       wr_idx_in;
   logic [brwm_pkg::QIDX_W-1:0]       rd_idx_ff;
   logic [brwm_pkg::QIDX_W-1:0]       rd_idx_in;
   logic [brwm_pkg::QCNT_W-1:0]       count_ff;
   logic [brwm_pkg::QCNT_W-1:0]       count_in;
   logic                              do_pop;

   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_idx_ff];
   assign count      = count_ff;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update; the front end never pushes into a full queue.
   always_comb begin
      wr_idx_in = push   ? wr_idx_ff + 1'b1 : wr_idx_ff;
      rd_idx_in = do_pop ? rd_idx_ff + 1'b1 : rd_idx_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_idx_ff] <= push_cmd;
      end
   end

endmodule

/* src/brwm_back.sv */
`timescale 1ns / 1ps

module brwm_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  brwm_pkg::cmd_type                q_cmd,
   output logic                             q_pop,
   output logic                             rsp_valid,
   output logic                             rsp_block_accepted,
   output logic [brwm_pkg::AVAIL_W-1:0]     rsp_bytes_available,
   output logic [brwm_pkg::DROP_W-1:0]      rsp_dropped_blocks,
   output logic [brwm_pkg::BYTE_W-1:0]      rsp_read_data,
   output logic [brwm_pkg::SBITS_W-1:0]     rsp_format_bits,
   output logic [brwm_pkg::RATE_W-1:0]      rsp_format_rate,
   output logic [brwm_pkg::CHANS_W-1:0]     rsp_format_channels
);

   localparam int PW = brwm_pkg::PTR_W;
   localparam int LW = brwm_pkg::LEN_W;

   // Byte store.
   logic [brwm_pkg::BYTE_W-1:0]   mem [brwm_pkg::BUF_BYTES];
   logic [brwm_pkg::BYTE_W-1:0]   rdata_ff;
   logic                          mem_we;
   logic                          mem_re;
   logic [brwm_pkg::ADDR_W-1:0]   mem_raddr;

   // Buffer state.
   brwm_pkg::back_state_type      state_ff;
   brwm_pkg::back_state_type      state_in;
   logic [PW-1:0]                 rp_ff, rp_in;
   logic [PW-1:0]                 wp_ff, wp_in;
   logic [PW-1:0]                 em_ff, em_in;
   logic [PW-1:0]                 fill_addr_ff, fill_addr_in;
   logic [PW-1:0]                 fill_left_ff, fill_left_in;
   logic [PW-1:0]                 amt_ff, amt_in;
   logic [brwm_pkg::DROP_W-1:0]   drop_ff, drop_in;
   logic [brwm_pkg::SBITS_W-1:0]  sbits_ff, sbits_in;
   logic [brwm_pkg::RATE_W-1:0]   srate_ff, srate_in;
   logic [brwm_pkg::CHANS_W-1:0]  schans_ff, schans_in;

   // Report stage control.
   logic                          rep_valid_ff, rep_valid_in;
   logic                          rep_acc_ff, rep_acc_in;
   logic                          rep_rd_ff, rep_rd_in;

   // Response registers.
   logic                          rsp_valid_ff;
   logic                          rsp_acc_ff;
   logic [brwm_pkg::AVAIL_W-1:0]  rsp_avail_ff;
   logic [brwm_pkg::DROP_W-1:0]   rsp_drop_ff;
   logic [brwm_pkg::BYTE_W-1:0]   rsp_rdata_ff;
   logic [brwm_pkg::SBITS_W-1:0]  rsp_bits_ff;
   logic [brwm_pkg::RATE_W-1:0]   rsp_rate_ff;
   logic [brwm_pkg::CHANS_W-1:0]  rsp_chans_ff;

   // Combinational terms.
   logic                          cur_straight;
   logic [PW-1:0]                 cur_level;
   logic                          fmt_chg;
   logic [PW-1:0]                 rp_e, wp_e, em_e;
   logic                          straight_e;
   logic [PW-1:0]                 room_end;
   logic [PW-1:0]                 gap;
   logic                          fit_here;
   logic                          fit_zero;
   logic [PW:0]                   adv_sum;
   logic [PW:0]                   rd_sum;
   logic                          rd_in_range;

   // Fill level of the current state, used by the reader and the report.
   assign cur_straight = (wp_ff >= rp_ff);
   assign cur_level    = cur_straight ? (wp_ff - rp_ff) : ((em_ff - rp_ff) + wp_ff);

   // Placement of a new block, after a possible format reset.
   assign fmt_chg = (q_cmd.sample_bits != sbits_ff) || (q_cmd.rate_hz != srate_ff) ||
                    (q_cmd.channel_count != schans_ff);
   assign rp_e       = fmt_chg ? '0 : rp_ff;
   assign wp_e       = fmt_chg ? '0 : wp_ff;
   assign em_e       = fmt_chg ? PW'(brwm_pkg::BUF_BYTES) : em_ff;
   assign straight_e = (wp_e >= rp_e);
   assign room_end   = PW'(brwm_pkg::BUF_BYTES) - wp_e;
   assign gap        = rp_e - wp_e;
   assign fit_here   = straight_e ? (q_cmd.block_len <= LW'(room_end))
                                  : (q_cmd.block_len < LW'(gap));
   assign fit_zero   = straight_e && (q_cmd.block_len < LW'(rp_e));

   // Reader advance, second step, and read address.
   assign adv_sum     = {1'b0, rp_ff} + {1'b0, amt_ff};
   assign rd_sum      = {1'b0, rp_ff} + (PW + 1)'(q_cmd.read_offset);
   assign rd_in_range = (rd_sum < (PW + 1)'(brwm_pkg::BUF_BYTES));
   assign mem_raddr   = rd_sum[brwm_pkg::ADDR_W-1:0];

   // Execution control and next state.
   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      em_in        = em_ff;
      fill_addr_in = fill_addr_ff;
      fill_left_in = fill_left_ff;
      amt_in       = amt_ff;
      drop_in      = drop_ff;
      sbits_in     = sbits_ff;
      srate_in     = srate_ff;
      schans_in    = schans_ff;
      rep_valid_in = 1'b0;
      rep_acc_in   = 1'b0;
      rep_rd_in    = 1'b0;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      unique case (state_ff)
         brwm_pkg::BK_RUN: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_cmd.mode)
                  brwm_pkg::MODE_OPEN: begin
                     rep_valid_in = 1'b1;
                     sbits_in     = q_cmd.sample_bits;
                     srate_in     = q_cmd.rate_hz;
                     schans_in    = q_cmd.channel_count;
                     rp_in        = rp_e;
                     wp_in        = wp_e;
                     em_in        = em_e;
                     if (fit_here) begin
                        rep_acc_in   = 1'b1;
                        fill_addr_in = wp_e;
                        fill_left_in = PW'(q_cmd.block_len);
                        wp_in        = wp_e + PW'(q_cmd.block_len);
                     end else if (fit_zero) begin
                        rep_acc_in   = 1'b1;
                        em_in        = wp_e;
                        fill_addr_in = '0;
                        fill_left_in = PW'(q_cmd.block_len);
                        wp_in        = PW'(q_cmd.block_len);
                     end else begin
                        fill_left_in = '0;
                        drop_in      = drop_ff + 1'b1;
                     end
                  end
                  brwm_pkg::MODE_DATA: begin
                     rep_valid_in = 1'b1;
                     if ((fill_left_ff != '0) &&
                         (fill_addr_ff < PW'(brwm_pkg::BUF_BYTES))) begin
                        mem_we       = 1'b1;
                        fill_addr_in = fill_addr_ff + 1'b1;
                        fill_left_in = fill_left_ff - 1'b1;
                     end
                  end
                  brwm_pkg::MODE_ADVANCE: begin
                     // Clamp the amount to the fill level, apply it next cycle.
                     if (LW'(q_cmd.advance_amount) > LW'(cur_level)) begin
                        amt_in = cur_level;
                     end else begin
                        amt_in = PW'(q_cmd.advance_amount);
                     end
                     state_in = brwm_pkg::BK_ADV;
                  end
                  brwm_pkg::MODE_READ: begin
                     rep_valid_in = 1'b1;
                     mem_re       = 1'b1;
                     rep_rd_in    = rd_in_range;
                  end
               endcase
            end
         end
         brwm_pkg::BK_ADV: begin
            rep_valid_in = 1'b1;
            state_in     = brwm_pkg::BK_RUN;
            if (!cur_straight) begin
               // Wrapped: on reaching the end mark the reader continues low.
               if (adv_sum >= {1'b0, em_ff}) begin
                  rp_in = PW'(adv_sum - {1'b0, em_ff});
                  em_in = PW'(brwm_pkg::BUF_BYTES);
               end else begin
                  rp_in = PW'(adv_sum);
               end
            end else begin
               // Straight: reaching the end empties the buffer to address 0.
               if (adv_sum >= (PW + 1)'(brwm_pkg::BUF_BYTES)) begin
                  rp_in = '0;
                  wp_in = '0;
               end else begin
                  rp_in = PW'(adv_sum);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brwm_pkg::BK_RUN;
         rp_ff        <= '0;
         wp_ff        <= '0;
         em_ff        <= PW'(brwm_pkg::BUF_BYTES);
         fill_addr_ff <= '0;
         fill_left_ff <= '0;
         amt_ff       <= '0;
         drop_ff      <= '0;
         sbits_ff     <= '0;
         srate_ff     <= '0;
         schans_ff    <= '0;
         rep_valid_ff <= 1'b0;
         rep_acc_ff   <= 1'b0;
         rep_rd_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         em_ff        <= em_in;
         fill_addr_ff <= fill_addr_in;
         fill_left_ff <= fill_left_in;
         amt_ff       <= amt_in;
         drop_ff      <= drop_in;
         sbits_ff     <= sbits_in;
         srate_ff     <= srate_in;
         schans_ff    <= schans_in;
         rep_valid_ff <= rep_valid_in;
         rep_acc_ff   <= rep_acc_in;
         rep_rd_ff    <= rep_rd_in;
      end
   end

   // Byte store write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fill_addr_ff[brwm_pkg::ADDR_W-1:0]] <= q_cmd.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Report stage: sample the state left by the command executed last cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_acc_ff   <= 1'b0;
         rsp_rdata_ff <= '0;
         rsp_avail_ff <= '0;
         rsp_drop_ff  <= '0;
         rsp_bits_ff  <= '0;
         rsp_rate_ff  <= '0;
         rsp_chans_ff <= '0;
      end else begin
         rsp_valid_ff <= rep_valid_ff;
         rsp_acc_ff   <= rep_valid_ff && rep_acc_ff;
         rsp_rdata_ff <= (rep_valid_ff && rep_rd_ff) ? rdata_ff : '0;
         if (rep_valid_ff) begin
            rsp_avail_ff <= brwm_pkg::AVAIL_W'(cur_level);
            rsp_drop_ff  <= drop_ff;
            rsp_bits_ff  <= sbits_ff;
            rsp_rate_ff  <= srate_ff;
            rsp_chans_ff <= schans_ff;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_block_accepted  = rsp_acc_ff;
   assign rsp_bytes_available = rsp_avail_ff;
   assign rsp_dropped_blocks  = rsp_drop_ff;
   assign rsp_read_data       = rsp_rdata_ff;
   assign rsp_format_bits     = rsp_bits_ff;
   assign rsp_format_rate     = rsp_rate_ff;
   assign rsp_format_channels = rsp_chans_ff;

endmodule

/* src/block_ring_buffer_with_wrap_mark.sv */
// Results pass the front end, command queue, execution unit, report stage and
// response registers; an advance adds the BK_ADV state. Throughput: one item per
// cycle while busy is low; the 4-entry queue absorbs an advance before busy rises.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset (synchronous, active high) clears pointers, counters, stored format and
// the queue at once; the byte store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module block_ring_buffer_with_wrap_mark (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [brwm_pkg::MODE_W-1:0]      req_mode,
   input  logic [brwm_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic [brwm_pkg::SBITS_W-1:0]     req_sample_bits,
   input  logic [brwm_pkg::RATE_W-1:0]      req_rate_hz,
   input  logic [brwm_pkg::CHANS_W-1:0]     req_channel_count,
   input  logic [brwm_pkg::FRAMES_W-1:0]    req_frame_count,
   input  logic [brwm_pkg::AMOUNT_W-1:0]    req_advance_amount,
   input  logic [brwm_pkg::OFFSET_W-1:0]    req_read_offset,
   output logic                             rsp_valid,
   output logic                             rsp_block_accepted,
   output logic [brwm_pkg::AVAIL_W-1:0]     rsp_bytes_available,
   output logic [brwm_pkg::DROP_W-1:0]      rsp_dropped_blocks,
   output logic [brwm_pkg::BYTE_W-1:0]      rsp_read_data,
   output logic [brwm_pkg::SBITS_W-1:0]     rsp_format_bits,
   output logic [brwm_pkg::RATE_W-1:0]      rsp_format_rate,
   output logic [brwm_pkg::CHANS_W-1:0]     rsp_format_channels
);

   logic                             q_push;
   brwm_pkg::cmd_type                q_push_cmd;
   logic                             q_pop;
   logic                             q_head_valid;
   brwm_pkg::cmd_type                q_head_cmd;
   logic [brwm_pkg::QCNT_W-1:0]      q_count;

   // Front end: accepts transfers and computes block lengths.
   brwm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_sample_bits    (req_sample_bits),
      .req_rate_hz        (req_rate_hz),
      .req_channel_count  (req_channel_count),
      .req_frame_count    (req_frame_count),
      .req_advance_amount (req_advance_amount),
      .req_read_offset    (req_read_offset),
      .q_count            (q_count),
      .q_push             (q_push),
      .q_push_cmd         (q_push_cmd)
   );

   // Command queue.
   brwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd),
      .count      (q_count)
   );

   // Execution unit with the byte store and the response registers.
   brwm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_head_valid),
      .q_cmd               (q_head_cmd),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_block_accepted  (rsp_block_accepted),
      .rsp_bytes_available (rsp_bytes_available),
      .rsp_dropped_blocks  (rsp_dropped_blocks),
      .rsp_read_data       (rsp_read_data),
      .rsp_format_bits     (rsp_format_bits),
      .rsp_format_rate     (rsp_format_rate),
      .rsp_format_channels (rsp_format_channels)
   );

endmodule

/* src/brwm_checker.sv */
`timescale 1ns / 1ps

module brwm_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_valid,
   input  logic                             rsp_block_accepted,
   input  logic [brwm_pkg::AVAIL_W-1:0]     rsp_bytes_available,
   input  logic [brwm_pkg::DROP_W-1:0]      rsp_dropped_blocks,
   input  logic [brwm_pkg::BYTE_W-1:0]      rsp_read_data
);

   // No result leaves the block in the cycle after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // Between strobes the flag and read byte stay quiet.
   a_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (!rsp_block_accepted && (rsp_read_data == '0)))
      else $error("result fields active without strobe");

   // A placed block never counts as a drop.
   a_accept_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_block_accepted && !$past(reset)) |-> $stable(rsp_dropped_blocks))
      else $error("drop count moved on an accepted block");

   // One result accounts for at most one dropped block.
   a_drop_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(reset) && !$stable(rsp_dropped_blocks)) |->
         (rsp_dropped_blocks == ($past(rsp_dropped_blocks) + 32'd1)))
      else $error("drop count jumped by more than one");

   // The fill level never exceeds the store.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bytes_available <= brwm_pkg::AVAIL_W'(brwm_pkg::BUF_BYTES)))
      else $error("bytes available beyond buffer size");

endmodule

bind block_ring_buffer_with_wrap_mark brwm_checker u_brwm_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_block_accepted  (rsp_block_accepted),
   .rsp_bytes_available (rsp_bytes_available),
   .rsp_dropped_blocks  (rsp_dropped_blocks),
   .rsp_read_data       (rsp_read_data)
);
